// ----- design/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg: shared widths, codes and stage types
// Widths of the triangle check datapath, all derived from the coordinate and
// ratio widths, plus the types that pass between the pipeline modules.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int COORD_BITS = 24;
  localparam int INDEX_BITS = 16;
  localparam int RATIO_BITS = 16;
  localparam int RATIO_FRAC = 8;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(768);

  // edge difference, squared side, side length sum
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int FULL_BITS  = 2 * DIFF_BITS;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int LEN_BITS   = SQ_BITS + 1;
  // cross product terms and their difference
  localparam int PROD_BITS  = 2 * COORD_BITS + 1;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int ABS_BITS   = CROSS_BITS - 1;
  // threshold compare: L^2 << frac against |cross| * ratio
  localparam int RHS_BITS   = ABS_BITS + RATIO_BITS;
  localparam int CMP_BITS   = RHS_BITS;

  // configuration port
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_WORD_LSB   = 2;
  localparam int CFG_INDEX_BITS = CFG_ADDR_BITS - CFG_WORD_LSB;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SKIN_RATIO = '0;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0] diff_t;

  typedef enum logic [1:0] {
    EDGE_AB = 2'd0,
    EDGE_BC = 2'd1,
    EDGE_CA = 2'd2
  } edge_t;

  typedef struct packed {
    index_t a;
    index_t b;
    index_t c;
  } idx3_t;

  // handoff from the geometry stages to the decision stages
  typedef struct packed {
    idx3_t                 idx;
    logic [LEN_BITS-1:0]   len_ab;
    logic [LEN_BITS-1:0]   len_bc;
    logic [LEN_BITS-1:0]   len_ca;
    logic [CROSS_BITS-1:0] area_x2;
  } geom_t;

  function automatic diff_t coord_diff(input coord_t p, input coord_t q);
    return $signed({p[COORD_BITS-1], p}) - $signed({q[COORD_BITS-1], q});
  endfunction

endpackage

// ----- design/stt_in_if.sv -----
// ----------------------------------------------------------------------------
// stt_in_if: triangle input channel
// One beat carries three vertex indices and their coordinates.
// ----------------------------------------------------------------------------
interface stt_in_if;
  import stt_pkg::*;

  logic   valid;
  logic   ready;
  index_t vertex_a_index;
  index_t vertex_b_index;
  index_t vertex_c_index;
  coord_t ax;
  coord_t ay;
  coord_t bx;
  coord_t by_coord;
  coord_t cx;
  coord_t cy;

  modport source (
    output valid, vertex_a_index, vertex_b_index, vertex_c_index,
    output ax, ay, bx, by_coord, cx, cy,
    input  ready
  );

  modport sink (
    input  valid, vertex_a_index, vertex_b_index, vertex_c_index,
    input  ax, ay, bx, by_coord, cx, cy,
    output ready
  );
endinterface

// ----- design/stt_out_if.sv -----
// ----------------------------------------------------------------------------
// stt_out_if: result channel
// One beat carries the skinny flag and the ordered longest-edge indices.
// ----------------------------------------------------------------------------
interface stt_out_if;
  import stt_pkg::*;

  logic   valid;
  logic   ready;
  logic   is_skinny;
  index_t edge_low_index;
  index_t edge_high_index;

  modport source (
    output valid, is_skinny, edge_low_index, edge_high_index,
    input  ready
  );

  modport sink (
    input  valid, is_skinny, edge_low_index, edge_high_index,
    output ready
  );
endinterface

// ----- design/stt_geom.sv -----
// ----------------------------------------------------------------------------
// stt_geom: edge geometry stages
// Three stages: edge differences, products, then side lengths and cross.
// ----------------------------------------------------------------------------
module stt_geom (
  input  logic          clk,
  input  logic          rst_n,
  stt_in_if.sink        in_ch,
  output logic          geom_valid,
  output stt_pkg::geom_t geom,
  input  logic          geom_ready
);
  import stt_pkg::*;

  // stage 1: edge vectors ab = a-b, bc = b-c, ca = c-a
  logic  s1_valid_r, s1_valid_nxt, s1_adv;
  idx3_t s1_idx_r;
  diff_t s1_ex_r [3];
  diff_t s1_ey_r [3];

  // stage 2: squared components and cross terms
  logic                s2_valid_r, s2_valid_nxt, s2_adv;
  idx3_t               s2_idx_r;
  logic [SQ_BITS-1:0]  s2_sqx_r [3];
  logic [SQ_BITS-1:0]  s2_sqy_r [3];
  logic [PROD_BITS-1:0] s2_p1_r, s2_p2_r;

  // stage 3: side lengths and signed doubled area
  logic                  s3_valid_r, s3_valid_nxt, s3_adv;
  idx3_t                 s3_idx_r;
  logic [LEN_BITS-1:0]   s3_len_r [3];
  logic [CROSS_BITS-1:0] s3_cross_r;

  logic signed [FULL_BITS-1:0] fx [3];
  logic signed [FULL_BITS-1:0] fy [3];
  logic signed [FULL_BITS-1:0] f1, f2;

  assign s3_adv = !s3_valid_r || geom_ready;
  assign s2_adv = !s2_valid_r || s3_adv;
  assign s1_adv = !s1_valid_r || s2_adv;
  assign in_ch.ready = s1_adv;

  assign s1_valid_nxt = s1_adv ? in_ch.valid : s1_valid_r;
  assign s2_valid_nxt = s2_adv ? s1_valid_r  : s2_valid_r;
  assign s3_valid_nxt = s3_adv ? s2_valid_r  : s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_idx_r.a <= in_ch.vertex_a_index;
      s1_idx_r.b <= in_ch.vertex_b_index;
      s1_idx_r.c <= in_ch.vertex_c_index;
      s1_ex_r[0] <= coord_diff(in_ch.ax, in_ch.bx);
      s1_ey_r[0] <= coord_diff(in_ch.ay, in_ch.by_coord);
      s1_ex_r[1] <= coord_diff(in_ch.bx, in_ch.cx);
      s1_ey_r[1] <= coord_diff(in_ch.by_coord, in_ch.cy);
      s1_ex_r[2] <= coord_diff(in_ch.cx, in_ch.ax);
      s1_ey_r[2] <= coord_diff(in_ch.cy, in_ch.ay);
    end
  end

  // cross = (b-a) x (c-a) = ab.y * ca.x - ab.x * ca.y
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fx[k] = s1_ex_r[k] * s1_ex_r[k];
      fy[k] = s1_ey_r[k] * s1_ey_r[k];
    end
    f1 = s1_ey_r[0] * s1_ex_r[2];
    f2 = s1_ex_r[0] * s1_ey_r[2];
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_idx_r <= s1_idx_r;
      for (int k = 0; k < 3; k++) begin
        s2_sqx_r[k] <= fx[k][SQ_BITS-1:0];
        s2_sqy_r[k] <= fy[k][SQ_BITS-1:0];
      end
      s2_p1_r <= f1[PROD_BITS-1:0];
      s2_p2_r <= f2[PROD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_idx_r <= s2_idx_r;
      for (int k = 0; k < 3; k++) begin
        s3_len_r[k] <= {1'b0, s2_sqx_r[k]} + {1'b0, s2_sqy_r[k]};
      end
      s3_cross_r <= {s2_p1_r[PROD_BITS-1], s2_p1_r} - {s2_p2_r[PROD_BITS-1], s2_p2_r};
    end
  end

  assign geom_valid   = s3_valid_r;
  assign geom.idx     = s3_idx_r;
  assign geom.len_ab  = s3_len_r[0];
  assign geom.len_bc  = s3_len_r[1];
  assign geom.len_ca  = s3_len_r[2];
  assign geom.area_x2 = s3_cross_r;

endmodule

// ----- design/stt_decide.sv -----
// ----------------------------------------------------------------------------
// stt_decide: longest edge and threshold stages
// Three stages: pick edge and take |cross|, scale by ratio, compare.
// ----------------------------------------------------------------------------
module stt_decide (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            geom_valid,
  input  stt_pkg::geom_t                  geom,
  output logic                            geom_ready,
  input  logic [stt_pkg::RATIO_BITS-1:0]  skin_ratio,
  stt_out_if.source                       out_ch
);
  import stt_pkg::*;

  // stage 4: best edge, its endpoints and |cross|
  logic                s4_valid_r, s4_valid_nxt, s4_adv;
  logic [LEN_BITS-1:0] s4_best_r;
  logic [ABS_BITS-1:0] s4_abs_r;
  index_t              s4_u_r, s4_v_r;

  // stage 5: both sides of the threshold compare, ordered indices
  logic                s5_valid_r, s5_valid_nxt, s5_adv;
  logic [CMP_BITS-1:0] s5_lhs_r, s5_rhs_r;
  index_t              s5_low_r, s5_high_r;

  // stage 6: result register
  logic   out_valid_r, out_valid_nxt, out_adv;
  logic   out_skinny_r;
  index_t out_low_r, out_high_r;

  edge_t                       sel;
  logic [LEN_BITS-1:0]         best_ab_bc;
  logic [LEN_BITS-1:0]         best;
  logic signed [CROSS_BITS-1:0] cross_s, cross_neg;
  logic [ABS_BITS-1:0]         cross_abs;
  index_t                      u, v;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign s5_adv  = !s5_valid_r || out_adv;
  assign s4_adv  = !s4_valid_r || s5_adv;
  assign geom_ready = s4_adv;

  assign s4_valid_nxt  = s4_adv  ? geom_valid : s4_valid_r;
  assign s5_valid_nxt  = s5_adv  ? s4_valid_r : s5_valid_r;
  assign out_valid_nxt = out_adv ? s5_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s4_valid_r  <= s4_valid_nxt;
      s5_valid_r  <= s5_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // earlier edge wins a tie: only a strictly longer side replaces it
  always_comb begin
    sel        = EDGE_AB;
    best_ab_bc = geom.len_ab;
    if (geom.len_bc > geom.len_ab) begin
      sel        = EDGE_BC;
      best_ab_bc = geom.len_bc;
    end
    best = best_ab_bc;
    if (geom.len_ca > best_ab_bc) begin
      sel  = EDGE_CA;
      best = geom.len_ca;
    end
    case (sel)
      EDGE_AB: begin
        u = geom.idx.a;
        v = geom.idx.b;
      end
      EDGE_BC: begin
        u = geom.idx.b;
        v = geom.idx.c;
      end
      EDGE_CA: begin
        u = geom.idx.c;
        v = geom.idx.a;
      end
      default: begin
        u = geom.idx.a;
        v = geom.idx.b;
      end
    endcase
    cross_s   = $signed(geom.area_x2);
    cross_neg = -cross_s;
    cross_abs = cross_s[CROSS_BITS-1] ? cross_neg[ABS_BITS-1:0] : cross_s[ABS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (s4_adv) begin
      s4_best_r <= best;
      s4_abs_r  <= cross_abs;
      s4_u_r    <= u;
      s4_v_r    <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_adv) begin
      s5_lhs_r  <= CMP_BITS'({s4_best_r, {RATIO_FRAC{1'b0}}});
      s5_rhs_r  <= CMP_BITS'(RHS_BITS'(s4_abs_r) * RHS_BITS'(skin_ratio));
      s5_low_r  <= (s4_u_r < s4_v_r) ? s4_u_r : s4_v_r;
      s5_high_r <= (s4_u_r < s4_v_r) ? s4_v_r : s4_u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_skinny_r <= s5_lhs_r > s5_rhs_r;
      out_low_r    <= s5_low_r;
      out_high_r   <= s5_high_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.is_skinny       = out_skinny_r;
  assign out_ch.edge_low_index  = out_low_r;
  assign out_ch.edge_high_index = out_high_r;

endmodule

// ----- design/skinny_triangle_detector.sv -----
// ----------------------------------------------------------------------------
// skinny_triangle_detector: triangle aspect ratio check
// Flags triangles whose longest side over its height exceeds skin_ratio and
// reports the longest edge's vertex indices, smaller index first.
// ----------------------------------------------------------------------------
//
//   port     direction  beat contents
//   -------  ---------  ----------------------------------------------------
//   in_ch    sink       vertex_a/b/c_index, ax, ay, bx, by_coord, cx, cy
//   out_ch   source     is_skinny, edge_low_index, edge_high_index
//   APB      slave      skin_ratio at byte address 0 (Q8.8, reset 3.0)
//
// One triangle enters per cycle while out_ch accepts results; each result
// passes through the six register stages (differences, products, sums,
// edge select, ratio multiply, compare and output register).
// rst_n is synchronous: it empties every stage and loads skin_ratio with 3.0.
// A stall at out_ch holds only the stages that are full: bubbles close up and
// in_ch keeps taking beats until the pipe is full, so nothing drops or repeats.
//
// Test: L^2 * 256 > skin_ratio * |(b-a) x (c-a)|, exact at full width; a
// zero-area triangle with a nonzero side always flags as skinny.
//
module skinny_triangle_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  stt_in_if.sink                               in_ch,
  stt_out_if.source                            out_ch,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [stt_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [stt_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [stt_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import stt_pkg::*;

  logic [RATIO_BITS-1:0]     skin_ratio_r, skin_ratio_nxt;
  logic [CFG_INDEX_BITS-1:0] reg_index;
  logic                      cfg_write;

  logic  geom_valid;
  logic  geom_ready;
  geom_t geom;

  // Register access: no wait states, write lands on the access phase.
  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_BITS-1:CFG_WORD_LSB];
  assign cfg_write = psel && penable && pwrite && pready;

  // Drop writes to any address other than the threshold register.
  assign skin_ratio_nxt = (cfg_write && (reg_index == REG_SKIN_RATIO)) ?
                          pwdata[RATIO_BITS-1:0] : skin_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skin_ratio_r <= RATIO_RESET;
    end else begin
      skin_ratio_r <= skin_ratio_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_SKIN_RATIO) begin
      prdata = CFG_DATA_BITS'(skin_ratio_r);
    end
  end

  // Stages 1-3: edge vectors, squares and cross terms, lengths and area.
  stt_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .geom_valid (geom_valid),
    .geom       (geom),
    .geom_ready (geom_ready)
  );

  // Stages 4-6: longest edge, threshold product, compare into out_ch.
  stt_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom_valid (geom_valid),
    .geom       (geom),
    .geom_ready (geom_ready),
    .skin_ratio (skin_ratio_r),
    .out_ch     (out_ch)
  );

endmodule
